// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TSA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tsa assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define TSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsa assertion failed");

`endif

// File: src/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// Constants, codes and controller/datapath interface types of the typed slot
// allocator.
// ----------------------------------------------------------------------------
package tsa_pkg;

    localparam int SLOTS_PER_TYPE = 256;
    localparam int NUM_TYPES      = 4;

    localparam int ACT_W  = 2;
    localparam int TYPE_W = 2;
    localparam int SLOT_W = 8;

    localparam int SLOT_FIELD_SPAN = 1 << SLOT_W;

    // Bitmap row geometry: one row holds WORD_W used bits and WORD_W mark bits
    localparam int WORD_W        = (SLOTS_PER_TYPE >= 32) ? 32 : 8;
    localparam int WORD_LG       = (WORD_W == 32) ? 5 : 3;
    localparam int RAM_W         = 2 * WORD_W;
    localparam int ROWS_PER_TYPE = (SLOTS_PER_TYPE + WORD_W - 1) / WORD_W;
    localparam int TOTAL_ROWS    = NUM_TYPES * ROWS_PER_TYPE;
    localparam int ROW_AW        = (TOTAL_ROWS > 1) ? $clog2(TOTAL_ROWS) : 1;

    // Alloc only searches slots that granted_slot can name
    localparam int SEARCH_SLOTS = (SLOTS_PER_TYPE < SLOT_FIELD_SPAN) ?
                                  SLOTS_PER_TYPE : SLOT_FIELD_SPAN;
    localparam int SEARCH_ROWS  = (SEARCH_SLOTS + WORD_W - 1) / WORD_W;
    localparam int LAST_BITS    = SEARCH_SLOTS - (SEARCH_ROWS - 1) * WORD_W;
    localparam logic [WORD_W-1:0] LAST_MASK = {WORD_W{1'b1}} >> (WORD_W - LAST_BITS);

    localparam logic [ACT_W-1:0] ACT_ALLOC = ACT_W'(0);
    localparam logic [ACT_W-1:0] ACT_FREE  = ACT_W'(1);
    localparam logic [ACT_W-1:0] ACT_MARK  = ACT_W'(2);
    localparam logic [ACT_W-1:0] ACT_SWEEP = ACT_W'(3);

    localparam logic STAT_DONE = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    typedef struct packed {
        logic load;
        logic issue_rd;
        logic row_wr;
        logic step;
        logic fail;
        logic out_load;
    } tsa_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             in_ok;
        logic             found;
        logic             last_row;
        logic             out_free;
    } tsa_stat_t;

endpackage

// File: src/tsa_ram.sv
// ----------------------------------------------------------------------------
// tsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsa_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [DATA_W-1:0]                           wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [DATA_W-1:0]                           rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/tsa_ctrl.sv
// ----------------------------------------------------------------------------
// tsa_ctrl
// Sequencer: accepts an item, walks the bitmap rows it needs, hands the
// result to the output register.
// ----------------------------------------------------------------------------
module tsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tsa_pkg::tsa_stat_t stat,
    output tsa_pkg::tsa_cmd_t  cmd
);
    import tsa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_CHK  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.in_ok ? ST_RD : ST_FIN;
                end
            end
            ST_RD:
            begin
                cmd.issue_rd = 1'b1;
                state_next   = ST_CHK;
            end
            ST_CHK:
            begin
                case (stat.act)
                    ACT_ALLOC:
                    begin
                        if (stat.found)
                        begin
                            cmd.row_wr = 1'b1;
                            state_next = ST_FIN;
                        end
                        else if (stat.last_row)
                        begin
                            cmd.fail   = 1'b1;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            cmd.step   = 1'b1;
                            state_next = ST_RD;
                        end
                    end
                    ACT_SWEEP:
                    begin
                        cmd.row_wr = 1'b1;
                        if (stat.last_row)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            cmd.step   = 1'b1;
                            state_next = ST_RD;
                        end
                    end
                    default:
                    begin
                        // free and mark touch a single row
                        cmd.row_wr = 1'b1;
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// File: src/tsa_dpath.sv
// ----------------------------------------------------------------------------
// tsa_dpath
// Bitmap storage (used and mark bits per row), row valid bits, first-free
// search, row update logic and the output register.
// ----------------------------------------------------------------------------
module tsa_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tsa_pkg::tsa_cmd_t           cmd,
    output tsa_pkg::tsa_stat_t          stat,
    input  logic [tsa_pkg::ACT_W-1:0]   action,
    input  logic [tsa_pkg::TYPE_W-1:0]  obj_type,
    input  logic [tsa_pkg::SLOT_W-1:0]  slot_index,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        status,
    output logic [tsa_pkg::SLOT_W-1:0]  granted_slot
);
    import tsa_pkg::*;

    logic [ACT_W-1:0]      act_reg;
    logic [WORD_LG-1:0]    bit_reg;
    logic [ROW_AW-1:0]     row_reg;
    logic [ROW_AW-1:0]     cnt_reg;
    logic                  rvalid_reg;
    logic [TOTAL_ROWS-1:0] row_valid_reg;
    logic                  res_status_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic                  out_valid_reg;
    logic                  out_status_reg;
    logic [SLOT_W-1:0]     out_slot_reg;

    logic                  type_ok;
    logic                  slot_ok;
    logic                  in_ok;
    logic [31:0]           start_calc;
    logic [ROW_AW-1:0]     start_row;
    logic [RAM_W-1:0]      ram_rdata;
    logic [RAM_W-1:0]      ram_wdata;
    logic [WORD_W-1:0]     eff_used;
    logic [WORD_W-1:0]     eff_mark;
    logic [WORD_W-1:0]     search_mask;
    logic [WORD_W-1:0]     free_vec;
    logic                  found;
    logic [WORD_LG-1:0]    alloc_idx;
    logic [WORD_W-1:0]     alloc_oh;
    logic [WORD_W-1:0]     sel_oh;
    logic [WORD_W-1:0]     new_used;
    logic [WORD_W-1:0]     new_mark;
    logic [SLOT_W-1:0]     granted;

    // ---- item decode at accept
    assign type_ok = (32'(obj_type) < NUM_TYPES);
    assign slot_ok = (32'(slot_index) < SLOTS_PER_TYPE);

    always_comb
    begin
        unique case (action)
            ACT_SWEEP: start_calc = '0;
            ACT_ALLOC: start_calc = 32'(obj_type) * ROWS_PER_TYPE;
            default:   start_calc = 32'(obj_type) * ROWS_PER_TYPE
                                    + (32'(slot_index) >> WORD_LG);
        endcase
    end
    assign start_row = start_calc[ROW_AW-1:0];

    always_comb
    begin
        unique case (action)
            ACT_SWEEP: in_ok = 1'b1;
            ACT_ALLOC: in_ok = type_ok;
            default:   in_ok = type_ok && slot_ok;
        endcase
    end

    // ---- row read; a row never written reads as all zero
    assign eff_used = rvalid_reg ? ram_rdata[WORD_W-1:0] : '0;
    assign eff_mark = rvalid_reg ? ram_rdata[RAM_W-1:WORD_W] : '0;

    assign search_mask = (cnt_reg == ROW_AW'(SEARCH_ROWS - 1)) ? LAST_MASK : '1;
    assign free_vec    = ~eff_used & search_mask;

    // lowest free bit of the row
    always_comb
    begin
        found     = 1'b0;
        alloc_idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (free_vec[b])
            begin
                found     = 1'b1;
                alloc_idx = WORD_LG'(b);
            end
        end
    end

    assign alloc_oh = WORD_W'(1) << alloc_idx;
    assign sel_oh   = WORD_W'(1) << bit_reg;
    assign granted  = SLOT_W'({cnt_reg, alloc_idx});

    always_comb
    begin
        unique case (act_reg)
            ACT_ALLOC:
            begin
                new_used = eff_used | alloc_oh;
                new_mark = eff_mark & ~alloc_oh;
            end
            ACT_FREE:
            begin
                new_used = eff_used & ~sel_oh;
                new_mark = eff_mark;
            end
            ACT_MARK:
            begin
                new_used = eff_used;
                new_mark = eff_mark | sel_oh;
            end
            default:
            begin
                // sweep: unmarked slots are freed, marks cleared
                new_used = eff_used & eff_mark;
                new_mark = '0;
            end
        endcase
    end
    assign ram_wdata = {new_mark, new_used};

    tsa_ram #(
        .DATA_W (RAM_W),
        .DEPTH  (TOTAL_ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.row_wr),
        .waddr (row_reg),
        .wdata (ram_wdata),
        .re    (cmd.issue_rd),
        .raddr (row_reg),
        .rdata (ram_rdata)
    );

    assign stat.act      = act_reg;
    assign stat.in_ok    = in_ok;
    assign stat.found    = found;
    assign stat.last_row = (act_reg == ACT_SWEEP) ? (row_reg == ROW_AW'(TOTAL_ROWS - 1))
                                                  : (cnt_reg == ROW_AW'(SEARCH_ROWS - 1));
    assign stat.out_free = !out_valid_reg || out_ready;

    // ---- control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.issue_rd)
            begin
                rvalid_reg <= row_valid_reg[row_reg];
            end
            if (cmd.row_wr)
            begin
                row_valid_reg[row_reg] <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg        <= action;
            bit_reg        <= slot_index[WORD_LG-1:0];
            row_reg        <= start_row;
            cnt_reg        <= '0;
            res_status_reg <= (action == ACT_ALLOC && !type_ok) ? STAT_FULL : STAT_DONE;
            res_slot_reg   <= '0;
        end
        else
        begin
            if (cmd.step)
            begin
                row_reg <= row_reg + ROW_AW'(1);
                cnt_reg <= cnt_reg + ROW_AW'(1);
            end
            if (cmd.row_wr && act_reg == ACT_ALLOC)
            begin
                res_slot_reg <= granted;
            end
            if (cmd.fail)
            begin
                res_status_reg <= STAT_FULL;
            end
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign granted_slot = out_slot_reg;

endmodule

// File: src/typed_slot_allocator_mark_sweep_unit.sv
// ----------------------------------------------------------------------------
// typed_slot_allocator_mark_sweep_unit
// Four typed slot pools in one used/mark bitmap, with alloc, free, mark and
// sweep items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries action, obj_type, slot_index.
//   Output channel (out_valid/out_ready) returns one item per input item:
//   status (1 = alloc found no free slot or had a bad type) and granted_slot.
//   The bitmap lives in a RAM of WORD_W-slot rows; each row holds the used
//   and mark bits. Every row visited is read in ST_RD and checked or
//   written in ST_CHK through the single RAM port pair.
//   Free and mark visit one row; alloc searches the rows of its type until
//   it finds a free slot or runs out; sweep visits all TOTAL_ROWS rows. A
//   bad type, or a bad slot on free or mark, skips the bitmap entirely.
//   One item is in flight at a time; the next is accepted as soon as the
//   previous result sits in the output register, even if not yet taken.
//   Reset clears the per-row valid bits, so the whole bitmap reads as free
//   and unmarked at once; no clearing pass is needed.
//   A stalled receiver holds the result; a finished item then waits until
//   the output register frees up.
// ----------------------------------------------------------------------------
module typed_slot_allocator_mark_sweep_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tsa_pkg::ACT_W-1:0]   action,
    input  logic [tsa_pkg::TYPE_W-1:0]  obj_type,
    input  logic [tsa_pkg::SLOT_W-1:0]  slot_index,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        status,
    output logic [tsa_pkg::SLOT_W-1:0]  granted_slot
);
    import tsa_pkg::*;

    tsa_cmd_t  cmd;
    tsa_stat_t stat;

    tsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsa_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .action       (action),
        .obj_type     (obj_type),
        .slot_index   (slot_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .granted_slot (granted_slot)
    );

endmodule

// File: src/tsa_checker.sv
// ----------------------------------------------------------------------------
// tsa_checker
// Port-level checks of the typed slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [tsa_pkg::ACT_W-1:0]   action,
    input logic [tsa_pkg::TYPE_W-1:0]  obj_type,
    input logic [tsa_pkg::SLOT_W-1:0]  slot_index,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        status,
    input logic [tsa_pkg::SLOT_W-1:0]  granted_slot
);
    import tsa_pkg::*;

    // stalled result holds
    `TSA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(granted_slot))

    // a failed alloc never names a slot
    `TSA_ASSERT(a_full_zero, clk, rst_n, (out_valid && status == STAT_FULL) |-> granted_slot == '0)

    // one item in flight: no accept right after an accept
    `TSA_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

    // an item's result never becomes valid right after its accept
    `TSA_ASSERT_NEXT(a_min_latency, clk, rst_n, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind typed_slot_allocator_mark_sweep_unit tsa_checker u_tsa_checker (.*);
